FILE: rtl/core/gsc_pkg.sv
// Shared types and constants for the grid step cost and neighbor block.
// No dependencies; every other file but gsc_ram imports this package.
package gsc_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int ID_W      = 12;
  localparam int COORD_W   = 6;
  localparam int KIND_W    = 2;
  localparam int MASK_W    = 8;
  localparam int SLOTS     = 3;
  localparam int CELL_W    = 2 * CFG_W;

  localparam logic [CFG_W-1:0] RESET_COLS = 7'd64;
  localparam logic [CFG_W-1:0] RESET_ROWS = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_COST  = 2'd1,
    KIND_NBR   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_WB,
    ST_EVAL,
    ST_DONE
  } state_e;

  // Quotient and remainder of both cell ids by the column count
  typedef struct packed {
    logic [ID_W-1:0]  quo_a;
    logic [CFG_W-1:0] rem_a;
    logic [ID_W-1:0]  quo_b;
    logic [CFG_W-1:0] rem_b;
  } div_res_t;

  // Neighbor offsets, order UL, U, UR, L, R, DL, D, DR; up is row - 1
  localparam logic signed [1:0] STEP_DX [MASK_W] =
    '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] STEP_DY [MASK_W] =
    '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};

endpackage

FILE: rtl/core/gsc_if.sv
// Channel interfaces of the grid step cost block: request, result, config.
// Depends on gsc_pkg for field widths.
interface gsc_req_if;
  import gsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [COORD_W-1:0]   cell_col;
  logic [COORD_W-1:0]   cell_row;
  logic                 blocked;
  logic [ID_W-1:0]      from_cell;
  logic [ID_W-1:0]      to_cell;

  modport source (output valid, kind, cell_col, cell_row, blocked, from_cell, to_cell,
                  input ready);
  modport sink   (input valid, kind, cell_col, cell_row, blocked, from_cell, to_cell,
                  output ready);
endinterface

interface gsc_res_if;
  import gsc_pkg::*;
  logic              valid;
  logic              ready;
  logic              reachable;
  logic              step_cost;
  logic [MASK_W-1:0] neighbor_mask;

  modport source (output valid, reachable, step_cost, neighbor_mask, input ready);
  modport sink   (input valid, reachable, step_cost, neighbor_mask, output ready);
endinterface

interface gsc_cfg_if;
  import gsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/gsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/gsc_div.sv
// Restoring divider: splits two cell ids by one column count, a bit a cycle.
// Depends on gsc_pkg.
module gsc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gsc_pkg::ID_W-1:0]      dvd_a_i,
  input  logic [gsc_pkg::ID_W-1:0]      dvd_b_i,
  input  logic [gsc_pkg::CFG_W-1:0]     dvs_i,
  output logic                          done_o,
  output gsc_pkg::div_res_t             res_o
);
  import gsc_pkg::*;

  localparam int CNT_W = $clog2(ID_W);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CFG_W-1:0]     dvs_q;
  logic [ID_W-1:0]      qa_q, qb_q;
  logic [CFG_W-1:0]     ra_q, rb_q;
  logic [CFG_W:0]       step_a, step_b;

  // Shift in one dividend bit, subtract the divisor when it fits
  function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] rem,
                                              input logic msb,
                                              input logic [CFG_W-1:0] dvs);
    logic [CFG_W:0] sh;
    logic [CFG_W:0] diff;
    sh   = {rem, msb};
    diff = sh - {1'b0, dvs};
    if (sh >= {1'b0, dvs}) begin
      return {1'b1, diff[CFG_W-1:0]};
    end
    return {1'b0, sh[CFG_W-1:0]};
  endfunction

  assign step_a = div_step(ra_q, qa_q[ID_W-1], dvs_q);
  assign step_b = div_step(rb_q, qb_q[ID_W-1], dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ID_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qa_q  <= dvd_a_i;
      qb_q  <= dvd_b_i;
      ra_q  <= '0;
      rb_q  <= '0;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      qa_q <= {qa_q[ID_W-2:0], step_a[CFG_W]};
      qb_q <= {qb_q[ID_W-2:0], step_b[CFG_W]};
      ra_q <= step_a[CFG_W-1:0];
      rb_q <= step_b[CFG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign res_o  = '{quo_a: qa_q, rem_a: ra_q, quo_b: qb_q, rem_b: rb_q};

endmodule

FILE: rtl/core/grid_step_cost_and_neighbors.sv
// Grid step cost and neighbor unit: blocked-cell bitmap for an 8-connected
// path-finding grid, diagonal steps may not cut a blocked corner.
// Depends on gsc_pkg, gsc_if (channels), gsc_ram (bitmap) and gsc_div.
//
// Channels: req_i carries one request (kind, cell_col, cell_row, blocked,
// from_cell, to_cell), res_o one result (reachable, step_cost,
// neighbor_mask) per request, in request order. cfg_i writes grid_cols
// (index 0) and grid_rows (index 1); it is always ready. The user must
// write it only while no request is in flight; the block does not enforce it.
// The bitmap is one RAM row per grid row, MAX_COLS bits wide, so one read
// brings a whole row. A request runs alone through a sequencer:
//   cost / neighbor query: restoring division of the ids by the column
//     count, three row reads and an evaluate step, then the result.
//   bitmap write: read-modify-write of one row.
//   unused kind: an all-zero result.
// The division sets the query rate; the single RAM read port sets the rest.
// Reset: the bitmap is cleared by a pass over all MAX_ROWS rows, one row a
// cycle, with req_i.ready low; cfg_i is taken during the pass.
// Stall: a result waits in the output register; the next request is
// accepted and worked on meanwhile, and the sequencer holds its finished
// result until the output register frees up.
module grid_step_cost_and_neighbors #(
  parameter int MAX_COLS = gsc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gsc_pkg::DEF_MAX_ROWS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gsc_cfg_if.sink    cfg_i,
  gsc_req_if.sink    req_i,
  gsc_res_if.source  res_o
);
  import gsc_pkg::*;

  localparam int CAW    = $clog2(MAX_COLS);
  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int RROW_W = ID_W + 1;
  localparam logic [RROW_W-1:0] ROW_LIM = RROW_W'(MAX_ROWS);
  localparam logic [1:0]        RD_LAST = 2'(SLOTS);

  state_e state_q, state_d;

  logic [CFG_W-1:0]   cols_q, rows_q;
  logic [CFG_W-1:0]   cols_use, rows_use;
  logic [CELL_W-1:0]  cells;

  logic [KIND_W-1:0]  kind_q;
  logic [COORD_W-1:0] wcol_q, wrow_q;
  logic               wbit_q;
  logic [ID_W-1:0]    from_q, to_q;

  logic [RAW-1:0]     clr_q;
  logic [1:0]         rd_cnt_q;
  logic [MAX_COLS-1:0] row_q [SLOTS];

  logic               res_reach_q, res_cost_q;
  logic [MASK_W-1:0]  res_mask_q;

  logic               out_valid_q;
  logic               out_reach_q, out_cost_q;
  logic [MASK_W-1:0]  out_mask_q;

  logic               req_ready, req_acc, div_start, div_done, out_load;
  div_res_t           div_res;

  logic               ram_we;
  logic [RAW-1:0]     ram_waddr, ram_raddr;
  logic [MAX_COLS-1:0] ram_wdata, ram_rdata, row_wr;
  logic [RROW_W-1:0]  rd_row;

  logic               wr_ok;
  logic               ev_reach, ev_cost;
  logic [MASK_W-1:0]  ev_mask;

  // ---------------------------------------------------------------------
  // Configuration: saturate the grid size to 1..MAX
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= RESET_COLS;
      rows_q <= RESET_ROWS;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_COLS: cols_q <= cfg_i.data;
        CFG_ROWS: rows_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_use = cols_q;
    if (cols_q == '0) begin
      cols_use = CFG_W'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_use = CFG_W'(MAX_COLS);
    end
    rows_use = rows_q;
    if (rows_q == '0) begin
      rows_use = CFG_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_use = CFG_W'(MAX_ROWS);
    end
  end

  assign cells = CELL_W'(cols_use) * CELL_W'(rows_use);

  // ---------------------------------------------------------------------
  // Bitmap RAM and id divider
  // ---------------------------------------------------------------------
  gsc_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_a_i (req_i.from_cell),
    .dvd_b_i (req_i.to_cell),
    .dvs_i   (cols_use),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign req_acc = req_i.valid && req_ready;

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == RAW'(MAX_ROWS - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_acc) begin
          case (kind_e'(req_i.kind))
            KIND_WRITE: state_d = ST_READ;
            KIND_COST:  state_d = ST_DIV;
            KIND_NBR:   state_d = ST_DIV;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_DIV:  if (div_done) state_d = ST_READ;
      ST_READ: begin
        if (rd_cnt_q == RD_LAST) begin
          state_d = (kind_q == KIND_WRITE) ? ST_WB : ST_EVAL;
        end
      end
      ST_WB:   state_d = ST_DONE;
      ST_EVAL: state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (RAM port, divider start, handshakes)
  // ---------------------------------------------------------------------
  always_comb begin
    req_ready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        div_start = req_i.valid &&
                    (req_i.kind == KIND_COST || req_i.kind == KIND_NBR);
      end
      ST_READ: ram_raddr = (rd_row < ROW_LIM) ? RAW'(rd_row) : '0;
      ST_WB: begin
        ram_we    = wr_ok;
        ram_waddr = RAW'(wrow_q);
        ram_wdata = row_wr;
      end
      ST_DONE: out_load = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign req_i.ready = req_ready;

  // Row to fetch for read slot rd_cnt_q. Cost: origin row, target row.
  // Neighbor: origin row - 1, origin row, origin row + 1.
  always_comb begin
    rd_row = {1'b0, div_res.quo_a};
    case (kind_e'(kind_q))
      KIND_WRITE: rd_row = RROW_W'(wrow_q);
      KIND_COST:  if (rd_cnt_q == 2'd1) rd_row = {1'b0, div_res.quo_b};
      KIND_NBR:   rd_row = {1'b0, div_res.quo_a} + RROW_W'(rd_cnt_q) - RROW_W'(1);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Write path: modify one bit of the fetched row
  // ---------------------------------------------------------------------
  assign wr_ok = (CFG_W'(wcol_q) < cols_use) && (CFG_W'(wrow_q) < rows_use);

  always_comb begin
    row_wr = row_q[0];
    row_wr[CAW'(wcol_q)] = wbit_q;
  end

  // ---------------------------------------------------------------------
  // Evaluate: step cost or neighbor mask from the fetched rows
  // ---------------------------------------------------------------------
  always_comb begin
    logic [CFG_W-1:0]   fx, tx;
    logic [ID_W-1:0]    fy, ty;
    logic               from_in, to_in, near_x, near_y, ortho;
    logic               tgt_blk, cor_a, cor_b, n_in, n_blk;
    logic signed [CELL_W-1:0] nx, ny;
    logic [MASK_W-1:0]  nbr_mask;

    fx = div_res.rem_a;
    fy = div_res.quo_a;
    tx = div_res.rem_b;
    ty = div_res.quo_b;
    from_in = CELL_W'(from_q) < cells;
    to_in   = CELL_W'(to_q) < cells;
    near_x  = (tx == fx) || ({1'b0, tx} == {1'b0, fx} + 8'd1) ||
              ({1'b0, fx} == {1'b0, tx} + 8'd1);
    near_y  = (ty == fy) || ({1'b0, ty} == {1'b0, fy} + 13'd1) ||
              ({1'b0, fy} == {1'b0, ty} + 13'd1);
    ortho   = (tx == fx) || (ty == fy);
    // Slot 1 holds the target row, slot 0 the origin row
    tgt_blk = row_q[1][CAW'(tx)];
    cor_a   = row_q[1][CAW'(fx)];
    cor_b   = row_q[0][CAW'(tx)];

    for (int i = 0; i < MASK_W; i++) begin
      nx = $signed({7'b0, fx}) + CELL_W'(STEP_DX[i]);
      ny = $signed({2'b0, fy}) + CELL_W'(STEP_DY[i]);
      n_in = !nx[CELL_W-1] && !ny[CELL_W-1] &&
             (nx < $signed(CELL_W'(cols_use))) && (ny < $signed(CELL_W'(rows_use)));
      n_blk = row_q[2'(int'(STEP_DY[i]) + 1)][n_in ? CAW'(nx) : CAW'(0)];
      nbr_mask[i] = n_in && !n_blk;
    end

    ev_reach = 1'b0;
    ev_cost  = 1'b0;
    ev_mask  = '0;
    case (kind_e'(kind_q))
      KIND_COST: begin
        if (from_in && to_in) begin
          if (from_q == to_q) begin
            ev_reach = 1'b1;
          end else if (!tgt_blk && near_x && near_y && (ortho || (!cor_a && !cor_b))) begin
            ev_reach = 1'b1;
            ev_cost  = 1'b1;
          end
        end
      end
      KIND_NBR: if (from_in) ev_mask = nbr_mask;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + RAW'(1);
      end
      // Wraps back to zero after the last slot is captured
      if (state_q == ST_READ) begin
        rd_cnt_q <= rd_cnt_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      kind_q      <= req_i.kind;
      wcol_q      <= req_i.cell_col;
      wrow_q      <= req_i.cell_row;
      wbit_q      <= req_i.blocked;
      from_q      <= req_i.from_cell;
      to_q        <= req_i.to_cell;
      res_reach_q <= 1'b0;
      res_cost_q  <= 1'b0;
      res_mask_q  <= '0;
    end
    // Capture the row requested in the cycle before
    if (state_q == ST_READ && rd_cnt_q != 2'd0) begin
      row_q[2'(rd_cnt_q - 2'd1)] <= ram_rdata;
    end
    if (state_q == ST_EVAL) begin
      res_reach_q <= ev_reach;
      res_cost_q  <= ev_cost;
      res_mask_q  <= ev_mask;
    end
    if (out_load) begin
      out_reach_q <= res_reach_q;
      out_cost_q  <= res_cost_q;
      out_mask_q  <= res_mask_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.reachable     = out_reach_q;
  assign res_o.step_cost     = out_cost_q;
  assign res_o.neighbor_mask = out_mask_q;

endmodule

FILE: rtl/core/gsc_chk.sv
// Port checker for grid_step_cost_and_neighbors, attached by bind below.
// Depends on gsc_pkg for field widths.
module gsc_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic                       reachable_i,
  input logic                       step_cost_i,
  input logic [gsc_pkg::MASK_W-1:0] neighbor_mask_i
);
  import gsc_pkg::*;

  // Hold a result until it is taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before it was taken");

  // One request at a time: drop ready right after a request is taken
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in work");

  a_cost_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && step_cost_i |-> reachable_i)
    else $error("step cost set on an unreachable step");

  a_mask_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (neighbor_mask_i != '0) |-> !reachable_i && !step_cost_i)
    else $error("neighbor mask mixed with a cost result");

endmodule

bind grid_step_cost_and_neighbors gsc_chk u_gsc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .reachable_i     (res_o.reachable),
  .step_cost_i     (res_o.step_cost),
  .neighbor_mask_i (res_o.neighbor_mask)
);

FILE: bench/tb_top.sv
// Self-checking bench for grid_step_cost_and_neighbors: obstacle writes, step cost and
// neighbor mask queries under random handshake gaps and several grid sizes.
// Depends on gsc_pkg and the gsc_if channel interfaces; no files are read.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gsc_pkg::*;

  localparam int MAX_COLS    = DEF_MAX_COLS;
  localparam int MAX_ROWS    = DEF_MAX_ROWS;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int LONG_HOLD   = 200;   // receiver hold-off, long enough to back up the input
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;  // cycles with no handshake on any channel
  localparam int TABLE_ROWS  = 24;

  // The package enum stops at 2; the fourth code does nothing.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Neighbor offsets in mask bit order UL, U, UR, L, R, DL, D, DR; up is row - 1.
  localparam int NBR_DX [MASK_W] = '{-1, 0, 1, -1, 1, -1, 0, 1};
  localparam int NBR_DY [MASK_W] = '{-1, -1, -1, 0, 0, 1, 1, 1};

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic               blocked;
    logic [ID_W-1:0]    from_cell;
    logic [ID_W-1:0]    to_cell;
  } grid_request_t;

  typedef struct packed {
    logic              reachable;
    logic              step_cost;
    logic [MASK_W-1:0] neighbor_mask;
  } grid_result_t;

  // One directed request; when has_fixed is set the typed result is the expectation.
  typedef struct packed {
    grid_request_t q;
    logic          has_fixed;
    grid_result_t  r;
  } stim_row_t;

  logic clk;
  logic rst_n;

  gsc_cfg_if cfg_bus ();
  gsc_req_if req_bus ();
  gsc_res_if res_bus ();

  grid_step_cost_and_neighbors u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: obstacle bits by (row, col) at full size, plus the two
  // size registers as written. Sizes are saturated to 1..MAX on use.
  // ---------------------------------------------------------------------------
  bit               obstacle_map [MAX_COLS * MAX_ROWS];
  logic [CFG_W-1:0] cols_reg = RESET_COLS;
  logic [CFG_W-1:0] rows_reg = RESET_ROWS;

  grid_result_t pending_results [$];
  int unsigned  mismatch_count = 0;

  // Driver-to-monitor hint: typed expectation of the request being offered.
  logic         fixed_on = 1'b0;
  grid_result_t fixed_result = '0;

  bit          idle_on = 1'b1;
  int unsigned res_gap = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned cols_in_use();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return 32'(cols_reg);
  endfunction

  function automatic int unsigned rows_in_use();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return 32'(rows_reg);
  endfunction

  // Out-of-grid positions count as free.
  function automatic bit obstacle_at(int col, int row);
    if (col < 0 || row < 0) return 1'b0;
    if (col >= int'(cols_in_use()) || row >= int'(rows_in_use())) return 1'b0;
    return obstacle_map[row * MAX_COLS + col];
  endfunction

  // Apply one request to the predictor and return the result it must give.
  function automatic grid_result_t predict_grid_step(grid_request_t q);
    grid_result_t r;
    int unsigned  ncols;
    int unsigned  nrows;
    int unsigned  ncells;
    int           fx, fy, tx, ty, ax, ay, nx, ny, i;
    r      = '0;
    ncols  = cols_in_use();
    nrows  = rows_in_use();
    ncells = ncols * nrows;
    fx     = q.from_cell % ncols;
    fy     = q.from_cell / ncols;
    tx     = q.to_cell % ncols;
    ty     = q.to_cell / ncols;
    case (q.kind)
      KIND_WRITE: begin
        if (q.cell_col < ncols && q.cell_row < nrows)
          obstacle_map[q.cell_row * MAX_COLS + q.cell_col] = q.blocked;
      end
      KIND_COST: begin
        if (q.from_cell < ncells && q.to_cell < ncells) begin
          if (q.from_cell == q.to_cell) begin
            r.reachable = 1'b1;
          end else begin
            ax = (tx > fx) ? tx - fx : fx - tx;
            ay = (ty > fy) ? ty - fy : fy - ty;
            // diagonal steps also need both corner cells free
            if (!obstacle_at(tx, ty) && ax <= 1 && ay <= 1 &&
                (ax + ay == 1 || (!obstacle_at(fx, ty) && !obstacle_at(tx, fy)))) begin
              r.reachable = 1'b1;
              r.step_cost = 1'b1;
            end
          end
        end
      end
      KIND_NBR: begin
        if (q.from_cell < ncells) begin
          for (i = 0; i < MASK_W; i++) begin
            nx = fx + NBR_DX[i];
            ny = fy + NBR_DY[i];
            if (nx >= 0 && ny >= 0 && nx < int'(ncols) && ny < int'(nrows) &&
                !obstacle_at(nx, ny))
              r.neighbor_mask[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Half the coordinates land in a small corner so that obstacles cluster.
  function automatic int unsigned pick_coord(int unsigned limit);
    if ($urandom_range(0, 1)) return $urandom_range(0, (limit < 6 ? limit : 6) - 1);
    return $urandom_range(0, limit - 1);
  endfunction

  // Mostly well-formed requests: in-grid writes and queries whose destination is
  // the origin or one of its neighbors; the rest carry raw ids and coordinates.
  // Unused fields always carry random values.
  function automatic grid_request_t make_random_request();
    grid_request_t q;
    int unsigned   pick, ncols, fcol, frow;
    int            dx, dy;
    q.kind      = KIND_SPARE;
    q.cell_col  = COORD_W'($urandom);
    q.cell_row  = COORD_W'($urandom);
    q.blocked   = 1'($urandom);
    q.from_cell = ID_W'($urandom);
    q.to_cell   = ID_W'($urandom);
    ncols = cols_in_use();
    fcol  = pick_coord(ncols);
    frow  = pick_coord(rows_in_use());
    pick  = $urandom_range(0, 99);
    if (pick < 30) begin
      q.kind = KIND_WRITE;
      if ($urandom_range(0, 6) != 0) begin
        q.cell_col = COORD_W'(fcol);
        q.cell_row = COORD_W'(frow);
      end
      q.blocked = ($urandom_range(0, 9) < 4);
    end else if (pick < 95) begin
      q.kind = (pick < 62) ? KIND_COST : KIND_NBR;
      if ($urandom_range(0, 7) != 0) q.from_cell = ID_W'(frow * ncols + fcol);
      if ($urandom_range(0, 4) != 0) begin
        // raw id arithmetic, so edge cells also wrap into the next row
        dx = int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, 2)) - 1;
        q.to_cell = ID_W'(int'(q.from_cell) + dy * int'(ncols) + dx);
      end
    end
    return q;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: all handshakes are sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    grid_request_t q;
    grid_result_t  want;
    grid_result_t  got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == CFG_COLS) cols_reg = cfg_bus.data;
        else if (cfg_bus.index == CFG_ROWS) rows_reg = cfg_bus.data;
      end
      if (req_bus.valid && req_bus.ready) begin
        q.kind      = req_bus.kind;
        q.cell_col  = req_bus.cell_col;
        q.cell_row  = req_bus.cell_row;
        q.blocked   = req_bus.blocked;
        q.from_cell = req_bus.from_cell;
        q.to_cell   = req_bus.to_cell;
        // run the predictor even for typed rows, so the obstacle map stays current
        want = predict_grid_step(q);
        pending_results.insert(pending_results.size(), fixed_on ? fixed_result : want);
      end
      if (res_bus.valid && res_bus.ready) begin
        got.reachable     = res_bus.reachable;
        got.step_cost     = res_bus.step_cost;
        got.neighbor_mask = res_bus.neighbor_mask;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with no request pending, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.reachable !== want.reachable)
            report_mismatch("reachable", int'(want.reachable), int'(got.reachable));
          if (got.step_cost !== want.step_cost)
            report_mismatch("step_cost", int'(want.step_cost), int'(got.step_cost));
          if (got.neighbor_mask !== want.neighbor_mask)
            report_mismatch("neighbor_mask", int'(want.neighbor_mask),
                            int'(got.neighbor_mask));
        end
        res_gap = idle_on ? $urandom_range(0, 6) : 0;
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk) begin
    if ((cfg_bus.valid && cfg_bus.ready) || (req_bus.valid && req_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result receiver: drop ready for a random gap after each result, and for a
  // long stretch whenever the stimulus asks for one.
  always @(negedge clk) begin
    if (holds_seen != holds_asked) begin
      holds_seen = holds_asked;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready = 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_bus.ready = 1'b0;
    end else begin
      res_bus.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: called and returning at a falling edge. Valid is left high on
  // return so a back-to-back request keeps it high without a glitch.
  // ---------------------------------------------------------------------------
  task automatic offer_request(grid_request_t q, logic has_fixed, grid_result_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.kind      = q.kind;
    req_bus.cell_col  = q.cell_col;
    req_bus.cell_row  = q.cell_row;
    req_bus.blocked   = q.blocked;
    req_bus.from_cell = q.from_cell;
    req_bus.to_cell   = q.to_cell;
    fixed_on          = has_fixed;
    fixed_result      = r;
    req_bus.valid     = 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    cfg_bus.valid = 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the request side idle until every expected result has come back.
  task automatic wait_results_drained();
    req_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed requests on the reset-size 64 x 64 grid. Ids: row * 64 + col.
  // ---------------------------------------------------------------------------
  stim_row_t stim_table [TABLE_ROWS] = '{
    // same cell, free grid
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd0},    1'b1, '{1'b1, 1'b0, 8'h00}},
    // masks of the top-left, bottom-right and an inner cell
    '{'{KIND_NBR,   6'd0,  6'd0,  1'b0, 12'd0,    12'd0},    1'b1, '{1'b0, 1'b0, 8'hD0}},
    '{'{KIND_NBR,   6'd0,  6'd0,  1'b0, 12'd4095, 12'd0},    1'b1, '{1'b0, 1'b0, 8'h0B}},
    '{'{KIND_NBR,   6'd0,  6'd0,  1'b0, 12'd65,   12'd0},    1'b1, '{1'b0, 1'b0, 8'hFF}},
    // orthogonal, diagonal, two apart, far corner
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd1},    1'b1, '{1'b1, 1'b1, 8'h00}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd65},   1'b1, '{1'b1, 1'b1, 8'h00}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd2},    1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd4095}, 1'b1, '{1'b0, 1'b0, 8'h00}},
    // block the last cell (all fields at their top) and cell (1, 0)
    '{'{KIND_WRITE, 6'd63, 6'd63, 1'b1, 12'hFFF,  12'hFFF},  1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{KIND_WRITE, 6'd1,  6'd0,  1'b1, 12'd0,    12'd0},    1'b1, '{1'b0, 1'b0, 8'h00}},
    // blocked destination; blocked origin does not matter
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd1},    1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd1,    12'd0},    1'b1, '{1'b1, 1'b1, 8'h00}},
    // diagonals that would cut the blocked corner, both ways
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd0,    12'd65},   1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd65,   12'd0},    1'b1, '{1'b0, 1'b0, 8'h00}},
    // masks lose the blocked neighbors
    '{'{KIND_NBR,   6'd0,  6'd0,  1'b0, 12'd65,   12'd0},    1'b1, '{1'b0, 1'b0, 8'hFD}},
    '{'{KIND_NBR,   6'd0,  6'd0,  1'b0, 12'd4030, 12'd0},    1'b1, '{1'b0, 1'b0, 8'h7F}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd4094, 12'd4095}, 1'b1, '{1'b0, 1'b0, 8'h00}},
    // same id wins over a blocked cell
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd4095, 12'd4095}, 1'b1, '{1'b1, 1'b0, 8'h00}},
    // unused kind with every field set
    '{'{KIND_SPARE, 6'd63, 6'd63, 1'b1, 12'hFFF,  12'hFFF},  1'b1, '{1'b0, 1'b0, 8'h00}},
    // clear the last cell again, then step diagonally onto it
    '{'{KIND_WRITE, 6'd63, 6'd63, 1'b0, 12'd0,    12'd0},    1'b1, '{1'b0, 1'b0, 8'h00}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd4030, 12'd4095}, 1'b1, '{1'b1, 1'b1, 8'h00}},
    // left edge mask; row-end to next row-start is not a neighbor
    '{'{KIND_NBR,   6'd0,  6'd0,  1'b0, 12'd2048, 12'd4095}, 1'b1, '{1'b0, 1'b0, 8'hD6}},
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd63,   12'd64},   1'b1, '{1'b0, 1'b0, 8'h00}},
    // inner diagonal, left to the predictor
    '{'{KIND_COST,  6'd0,  6'd0,  1'b0, 12'd1000, 12'd1065}, 1'b0, '{1'b0, 1'b0, 8'h00}}
  };

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : run_stimulus
    logic [CFG_W-1:0] new_cols;
    logic [CFG_W-1:0] new_rows;
    int               p, n;
    rst_n             = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_COLS;
    cfg_bus.data      = '0;
    req_bus.valid     = 1'b0;
    req_bus.kind      = KIND_WRITE;
    req_bus.cell_col  = '0;
    req_bus.cell_row  = '0;
    req_bus.blocked   = 1'b0;
    req_bus.from_cell = '0;
    req_bus.to_cell   = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part; the block's clearing pass holds ready low meanwhile.
    for (n = 0; n < TABLE_ROWS; n++)
      offer_request(stim_table[n].q, stim_table[n].has_fixed, stim_table[n].r);
    wait_results_drained();

    // Random phases, each at its own grid size. Sizes 0 and above 64 saturate.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin new_cols = 7'd0;   new_rows = 7'd0;   end
        1:       begin new_cols = 7'd1;   new_rows = 7'd64;  end
        2:       begin new_cols = 7'd64;  new_rows = 7'd1;   end
        3:       begin new_cols = 7'd127; new_rows = 7'd127; end
        4:       begin new_cols = 7'd2;   new_rows = 7'd2;   end
        5:       begin new_cols = 7'd8;   new_rows = 7'd5;   end
        9:       begin new_cols = RESET_COLS; new_rows = RESET_ROWS; end
        default: begin new_cols = CFG_W'($urandom); new_rows = CFG_W'($urandom); end
      endcase
      write_register(CFG_COLS, new_cols);
      write_register(CFG_ROWS, new_rows);
      cfg_bus.valid = 1'b0;

      // every third phase runs both sides back to back
      idle_on = (p % 3 != 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // stall the receiver while requests keep coming
        if (p == 3 && n == 60) holds_asked++;
        // pause the sender until the block has answered everything
        if (p == 5 && n == 100) wait_results_drained();
        offer_request(make_random_request(), 1'b0, '0);
      end
      wait_results_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: grid_step_cost_and_neighbors.f
rtl/core/gsc_pkg.sv
rtl/core/gsc_if.sv
rtl/core/gsc_ram.sv
rtl/core/gsc_div.sv
rtl/core/grid_step_cost_and_neighbors.sv
rtl/core/gsc_chk.sv
bench/tb_top.sv
